>>> hdl/roh_pkg.sv
// Shared constants, types and control bundles for the ranked occurrence histogram.
package roh_pkg;

    localparam int NUMBERS    = 45;
    localparam int COUNT_BITS = 9;
    localparam int IDX_W      = $clog2(NUMBERS);

    localparam int NUMBER_W = 6;
    localparam int OCC_W    = 9;
    localparam int RANK_W   = 6;
    localparam int MASK_W   = 45;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(NUMBERS - 1);

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_EMIT  = 1'b1;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [IDX_W-1:0]      t_idx;

    typedef enum logic [1:0] {
        ST_ACC,
        ST_RANK,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic   inc;
        logic   clear;
        logic   rank_clr;
        logic   rank_step;
        t_count ref_cnt;
        t_idx   ref_idx;
    } t_lane_ctrl;

    typedef struct packed {
        logic load;
        t_idx pos;
        logic last;
    } t_merge_ctrl;

endpackage

>>> hdl/roh_lane.sv
// One number's lane: saturating occurrence counter and rank accumulator.
module roh_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  roh_pkg::t_lane_ctrl i_ctrl,
    input  roh_pkg::t_idx      i_lane_idx,
    input  logic               i_hit,
    output roh_pkg::t_count    o_count,
    output roh_pkg::t_idx      o_rank
);
    import roh_pkg::*;

    t_count r_count;
    t_count n_count;
    t_idx   r_rank;
    t_idx   n_rank;
    logic   ref_ahead;

    // the reference number outranks this lane
    assign ref_ahead = (i_ctrl.ref_cnt > r_count) ||
                       ((i_ctrl.ref_cnt == r_count) && (i_ctrl.ref_idx < i_lane_idx));

    always_comb begin
        n_count = r_count;
        if (i_ctrl.clear) begin
            n_count = '0;
        end else if (i_ctrl.inc && i_hit && (r_count != COUNT_MAX)) begin
            n_count = r_count + t_count'(1);
        end
        n_rank = r_rank;
        if (i_ctrl.rank_clr) begin
            n_rank = '0;
        end else if (i_ctrl.rank_step && ref_ahead) begin
            n_rank = r_rank + t_idx'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rank  <= '0;
        end else begin
            r_count <= n_count;
            r_rank  <= n_rank;
        end
    end

    assign o_count = r_count;
    assign o_rank  = r_rank;

endmodule

>>> hdl/roh_merge.sv
// Merge stage: picks the lane holding the current rank and registers the result.
module roh_merge (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  roh_pkg::t_merge_ctrl              i_ctrl,
    input  roh_pkg::t_count                   i_counts [roh_pkg::NUMBERS],
    input  roh_pkg::t_idx                     i_ranks  [roh_pkg::NUMBERS],
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [roh_pkg::NUMBER_W-1:0]      o_number,
    output logic [roh_pkg::OCC_W-1:0]         o_occurrences,
    output logic [roh_pkg::RANK_W-1:0]        o_rank,
    output logic                              o_last
);
    import roh_pkg::*;

    logic [NUMBERS-1:0] match;
    t_idx               sel_idx;
    t_count             sel_cnt;
    logic [IDX_W:0]     num_full;
    logic               r_valid;
    logic               n_valid;

    always_comb begin
        sel_idx = '0;
        sel_cnt = '0;
        for (int l = 0; l < NUMBERS; l++) begin
            match[l] = (i_ranks[l] == i_ctrl.pos);
            if (match[l]) begin
                sel_idx = t_idx'(l);
                sel_cnt = i_counts[l];
            end
        end
        num_full = {1'b0, sel_idx} + (IDX_W + 1)'(1);
    end

    always_comb begin
        n_valid = r_valid;
        if (i_ctrl.load) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            o_number      <= NUMBER_W'(num_full);
            o_occurrences <= OCC_W'(sel_cnt);
            o_rank        <= RANK_W'(i_ctrl.pos);
            o_last        <= i_ctrl.last;
        end
    end

    assign o_out_valid = r_valid;

    a_rank_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.load |-> $onehot(match))
        else $error("lane ranks do not form a permutation");

    a_last_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.load && i_ctrl.last) |=> (o_rank == RANK_W'(NUMBERS - 1)) && o_last)
        else $error("last flag on wrong rank");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.load |=> o_out_valid)
        else $error("loaded result not presented");

endmodule

>>> hdl/ranked_occurrence_histogram_unit.sv
// Top level: counter lanes, rank sequencer and output merge of the occurrence histogram.
//
//  channel  direction  handshake                 payload
//  input    in         i_in_valid / o_in_stall   i_op, i_presence_mask
//  output   out        o_out_valid / i_out_stall o_number, o_occurrences, o_rank, o_last
//
// An accumulate transaction makes all lanes count in parallel.
// An emit transaction first ranks every lane (one reference count
// broadcast to every lane per cycle) and then outputs NUMBERS results, one
// result per cycle when the output is not stalled. Input stalls meanwhile.
// Synchronous active-low reset clears counters, ranks and the output valid.
module ranked_occurrence_histogram_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_op,
    input  logic [roh_pkg::MASK_W-1:0]    i_presence_mask,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [roh_pkg::NUMBER_W-1:0]  o_number,
    output logic [roh_pkg::OCC_W-1:0]     o_occurrences,
    output logic [roh_pkg::RANK_W-1:0]    o_rank,
    output logic                          o_last
);
    import roh_pkg::*;

    t_state      r_state;
    t_state      n_state;
    t_idx        r_ref;
    t_idx        n_ref;
    t_idx        r_pos;
    t_idx        n_pos;
    logic        accept;
    logic        load;
    t_lane_ctrl  lane_ctrl;
    t_merge_ctrl merge_ctrl;
    t_count      counts [NUMBERS];
    t_idx        ranks  [NUMBERS];

    assign o_in_stall = (r_state != ST_ACC);
    assign accept     = i_in_valid && !o_in_stall;
    assign load       = (r_state == ST_EMIT) && (!o_out_valid || !i_out_stall);

    always_comb begin
        n_state             = r_state;
        n_ref               = r_ref;
        n_pos               = r_pos;
        lane_ctrl.inc       = 1'b0;
        lane_ctrl.clear     = 1'b0;
        lane_ctrl.rank_clr  = 1'b0;
        lane_ctrl.rank_step = 1'b0;
        lane_ctrl.ref_cnt   = counts[r_ref];
        lane_ctrl.ref_idx   = r_ref;
        merge_ctrl.load     = load;
        merge_ctrl.pos      = r_pos;
        merge_ctrl.last     = (r_pos == LAST_IDX);
        case (r_state)
            ST_ACC: begin
                if (accept && (i_op == OP_ACCUM)) begin
                    lane_ctrl.inc = 1'b1;
                end else if (accept) begin
                    lane_ctrl.rank_clr = 1'b1;
                    n_ref   = '0;
                    n_state = ST_RANK;
                end
            end
            ST_RANK: begin
                lane_ctrl.rank_step = 1'b1;
                n_ref = r_ref + t_idx'(1);
                if (r_ref == LAST_IDX) begin
                    n_ref   = '0;
                    n_pos   = '0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load) begin
                    n_pos = r_pos + t_idx'(1);
                    if (r_pos == LAST_IDX) begin
                        n_pos           = '0;
                        lane_ctrl.clear = 1'b1;
                        n_state         = ST_ACC;
                    end
                end
            end
            default: begin
                n_state = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
            r_ref   <= '0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_ref   <= n_ref;
            r_pos   <= n_pos;
        end
    end

    for (genvar g = 0; g < NUMBERS; g++) begin : g_lane
        roh_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (lane_ctrl),
            .i_lane_idx (t_idx'(g)),
            .i_hit      (i_presence_mask[g]),
            .o_count    (counts[g]),
            .o_rank     (ranks[g])
        );
    end

    roh_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (merge_ctrl),
        .i_counts      (counts),
        .i_ranks       (ranks),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_number      (o_number),
        .o_occurrences (o_occurrences),
        .o_rank        (o_rank),
        .o_last        (o_last)
    );

    a_emit_starts_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_op == OP_EMIT)) |=> (r_state == ST_RANK) && (r_ref == '0))
        else $error("emit did not start ranking");

    a_rank_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RANK) && (r_ref == LAST_IDX)) |=>
            (r_state == ST_EMIT) && (r_pos == '0))
        else $error("ranking did not hand over to output");

    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && (r_pos == LAST_IDX)) |=> (r_state == ST_ACC) && (counts[0] == '0))
        else $error("counters not cleared after emit");

endmodule
